/* hdl/dc1d_pkg.sv */
// ----------------------------------------------------------------------------
// dc1d_pkg
// shared types and constants of the dilated conv1d engine: field widths,
// opcodes, register indexes, configuration bundle and control structs
// ----------------------------------------------------------------------------
package dc1d_pkg;

    localparam int DATA_W      = 24;   // signed q11.12 value width
    localparam int FRAC_W      = 12;   // fraction bits
    localparam int PROD_W      = 2 * DATA_W;
    localparam int CHAN_W      = 6;
    localparam int TAP_W       = 3;
    localparam int TIME_W      = 9;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int MAX_DIL     = 64;   // largest usable tap spacing

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_WEIGHT,
        OP_LOAD_BIAS,
        OP_LOAD_SAMPLE,
        OP_COMPUTE
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_CHANNELS,
        CFG_OUT_CHANNELS,
        CFG_KERNEL_TAPS,
        CFG_TAP_SPACING,
        CFG_LEFT_PADDING,
        CFG_SEQUENCE_LENGTH,
        CFG_BIAS_ENABLE
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [6:0] in_channels;
        logic [6:0] out_channels;
        logic [3:0] kernel_taps;
        logic [6:0] tap_spacing;
        logic [8:0] left_padding;
        logic [9:0] sequence_length;
        logic       bias_enable;
    } t_cfg;

    // control for the multiply-accumulate unit, aligned with the read issue
    typedef struct packed {
        logic init;     // load accumulator with bias (or zero)
        logic tap_en;   // tap position inside the sequence
        logic bias_en;
    } t_mac_ctl;

    typedef struct packed {
        logic done;     // result handed to the output register
        logic err;      // index error on this item
    } t_seq_stat;

endpackage

/* hdl/dc1d_stores.sv */
// ----------------------------------------------------------------------------
// dc1d_stores
// weight, bias and sample memories: one write port for load items and one
// registered read port each for the compute sequencer
// ----------------------------------------------------------------------------
module dc1d_stores #(
    parameter int MAX_IN_CHANNELS  = 64,
    parameter int MAX_OUT_CHANNELS = 64,
    parameter int MAX_TAPS         = 8,
    parameter int MAX_LENGTH       = 512,
    localparam int IC_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1,
    localparam int TP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int LI_W = $clog2(MAX_LENGTH)
) (
    input  logic                                i_clk,
    input  logic                                i_w_we,
    input  logic                                i_b_we,
    input  logic                                i_s_we,
    input  logic [dc1d_pkg::CHAN_W-1:0]         i_ld_oc,
    input  logic [dc1d_pkg::CHAN_W-1:0]         i_ld_ic,
    input  logic [dc1d_pkg::TAP_W-1:0]          i_ld_tap,
    input  logic [dc1d_pkg::TIME_W-1:0]         i_ld_time,
    input  logic signed [dc1d_pkg::DATA_W-1:0]  i_ld_value,
    input  logic [dc1d_pkg::CHAN_W-1:0]         i_rd_oc,
    input  logic [IC_W-1:0]                     i_rd_ic,
    input  logic [TP_W-1:0]                     i_rd_tap,
    input  logic [LI_W-1:0]                     i_rd_pos,
    output logic signed [dc1d_pkg::DATA_W-1:0]  o_w_data,
    output logic signed [dc1d_pkg::DATA_W-1:0]  o_b_data,
    output logic signed [dc1d_pkg::DATA_W-1:0]  o_s_data
);
    import dc1d_pkg::*;

    localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS;
    localparam int S_DEPTH = MAX_IN_CHANNELS * MAX_LENGTH;
    localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int BA_W    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int SA_W    = $clog2(S_DEPTH);

    logic signed [DATA_W-1:0] r_weight_mem [W_DEPTH];
    logic signed [DATA_W-1:0] r_bias_mem   [MAX_OUT_CHANNELS];
    logic signed [DATA_W-1:0] r_sample_mem [S_DEPTH];

    logic            ld_oc_ok;
    logic            ld_ic_ok;
    logic            ld_tm_ok;
    logic [WA_W-1:0] w_wr_addr;
    logic [WA_W-1:0] w_rd_addr;
    logic [BA_W-1:0] b_wr_addr;
    logic [BA_W-1:0] b_rd_addr;
    logic [SA_W-1:0] s_wr_addr;
    logic [SA_W-1:0] s_rd_addr;

    // loads beyond the store bounds are dropped
    assign ld_oc_ok = 32'(i_ld_oc) < MAX_OUT_CHANNELS;
    assign ld_ic_ok = 32'(i_ld_ic) < MAX_IN_CHANNELS;
    assign ld_tm_ok = 32'(i_ld_time) < MAX_LENGTH;

    assign w_wr_addr = WA_W'(32'(i_ld_oc) * (MAX_IN_CHANNELS * MAX_TAPS)
                           + 32'(i_ld_ic) * MAX_TAPS + 32'(i_ld_tap));
    assign w_rd_addr = WA_W'(32'(i_rd_oc) * (MAX_IN_CHANNELS * MAX_TAPS)
                           + 32'(i_rd_ic) * MAX_TAPS + 32'(i_rd_tap));
    assign b_wr_addr = BA_W'(i_ld_oc);
    assign b_rd_addr = BA_W'(i_rd_oc);
    assign s_wr_addr = SA_W'(32'(i_ld_ic) * MAX_LENGTH + 32'(i_ld_time));
    assign s_rd_addr = SA_W'(32'(i_rd_ic) * MAX_LENGTH + 32'(i_rd_pos));

    always_ff @(posedge i_clk) begin
        if (i_w_we && ld_oc_ok && ld_ic_ok && (32'(i_ld_tap) < MAX_TAPS)) begin
            r_weight_mem[w_wr_addr] <= i_ld_value;
        end
        o_w_data <= r_weight_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_b_we && ld_oc_ok) begin
            r_bias_mem[b_wr_addr] <= i_ld_value;
        end
        o_b_data <= r_bias_mem[b_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_s_we && ld_ic_ok && ld_tm_ok) begin
            r_sample_mem[s_wr_addr] <= i_ld_value;
        end
        o_s_data <= r_sample_mem[s_rd_addr];
    end

endmodule

/* hdl/dc1d_mac.sv */
// ----------------------------------------------------------------------------
// dc1d_mac
// shared multiply-accumulate unit: registered product, wide accumulator,
// round half up to q11.12 and saturate
// ----------------------------------------------------------------------------
module dc1d_mac #(
    parameter int MAX_IN_CHANNELS = 64,
    parameter int MAX_TAPS        = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dc1d_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [dc1d_pkg::DATA_W-1:0]  i_w,
    input  logic signed [dc1d_pkg::DATA_W-1:0]  i_s,
    input  logic signed [dc1d_pkg::DATA_W-1:0]  i_b,
    output logic signed [dc1d_pkg::DATA_W-1:0]  o_res,
    output logic                                o_sat
);
    import dc1d_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(MAX_IN_CHANNELS * MAX_TAPS + 1) + 1;

    t_mac_ctl                 r_ctl_d1;   // aligned with memory read data
    logic                     r_prod_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  bias_ext;
    logic signed [ACC_W-1:0]  rnd;
    logic                     sat_hi;
    logic                     sat_lo;

    assign bias_ext = $signed({{(ACC_W - DATA_W - FRAC_W){i_b[DATA_W-1]}}, i_b,
                               {FRAC_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d1 <= '0;
            r_prod_v <= 1'b0;
        end else begin
            r_ctl_d1 <= i_ctl;
            r_prod_v <= r_ctl_d1.tap_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_w * i_s;
        if (r_ctl_d1.init) begin
            r_acc <= r_ctl_d1.bias_en ? bias_ext : '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // floor((acc + half) / 2^frac), then clip to 24 bits
    assign rnd    = (r_acc + ACC_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
    assign sat_hi = !rnd[ACC_W-1] && (|rnd[ACC_W-2:DATA_W-1]);
    assign sat_lo = rnd[ACC_W-1] && !(&rnd[ACC_W-2:DATA_W-1]);
    assign o_sat  = sat_hi || sat_lo;

    always_comb begin
        if (sat_hi) begin
            o_res = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (sat_lo) begin
            o_res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_res = rnd[DATA_W-1:0];
        end
    end

endmodule

/* hdl/dc1d_seq.sv */
// ----------------------------------------------------------------------------
// dc1d_seq
// compute sequencer: checks indexes, walks input channels and taps, issues
// store reads and mac control, waits for the pipeline and hands off results
// ----------------------------------------------------------------------------
module dc1d_seq #(
    parameter int MAX_IN_CHANNELS  = 64,
    parameter int MAX_OUT_CHANNELS = 64,
    parameter int MAX_TAPS         = 8,
    parameter int MAX_LENGTH       = 512,
    localparam int IC_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1,
    localparam int TP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int LI_W = $clog2(MAX_LENGTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dc1d_pkg::t_cfg                i_cfg,
    input  logic                          i_start,     // compute item accepted
    input  logic [dc1d_pkg::CHAN_W-1:0]   i_oc,
    input  logic [dc1d_pkg::TIME_W-1:0]   i_tm,
    input  logic                          i_out_free,
    output logic                          o_ready,
    output logic [dc1d_pkg::CHAN_W-1:0]   o_oc,
    output logic [dc1d_pkg::TIME_W-1:0]   o_tm,
    output logic [IC_W-1:0]               o_ic,
    output logic [TP_W-1:0]               o_tap,
    output logic [LI_W-1:0]               o_pos,
    output dc1d_pkg::t_mac_ctl            o_ctl,
    output dc1d_pkg::t_seq_stat           o_stat
);
    import dc1d_pkg::*;

    localparam int OC_CNT_W = $clog2(MAX_OUT_CHANNELS + 1);
    localparam int LC_W     = $clog2(MAX_LENGTH + 1);
    localparam int POS_W    = $clog2(MAX_TAPS * MAX_DIL + 512 + MAX_LENGTH) + 2;

    t_state                  r_state, n_state;
    logic [CHAN_W-1:0]       r_oc, n_oc;
    logic [TIME_W-1:0]       r_tm, n_tm;
    logic                    r_err, n_err;
    logic [IC_W-1:0]         r_ic, n_ic;
    logic [TP_W-1:0]         r_tp, n_tp;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_drain, n_drain;

    logic [IC_W-1:0]         in_last;
    logic [TP_W-1:0]         tap_last;
    logic [6:0]              dil;
    logic [LC_W-1:0]         len;
    logic [OC_CNT_W-1:0]     n_out;
    logic                    idx_err;
    logic                    pos_in;
    logic [POS_W-1:0]        pos_base;

    // registers used saturated to their legal ranges
    always_comb begin
        if (i_cfg.in_channels == '0) begin
            in_last = '0;
        end else if (32'(i_cfg.in_channels) > MAX_IN_CHANNELS) begin
            in_last = IC_W'(MAX_IN_CHANNELS - 1);
        end else begin
            in_last = IC_W'(i_cfg.in_channels - 7'd1);
        end

        if (i_cfg.kernel_taps == '0) begin
            tap_last = '0;
        end else if (32'(i_cfg.kernel_taps) > MAX_TAPS) begin
            tap_last = TP_W'(MAX_TAPS - 1);
        end else begin
            tap_last = TP_W'(i_cfg.kernel_taps - 4'd1);
        end

        if (i_cfg.tap_spacing == '0) begin
            dil = 7'd1;
        end else if (32'(i_cfg.tap_spacing) > MAX_DIL) begin
            dil = 7'(MAX_DIL);
        end else begin
            dil = i_cfg.tap_spacing;
        end

        if (i_cfg.sequence_length == '0) begin
            len = LC_W'(1);
        end else if (32'(i_cfg.sequence_length) > MAX_LENGTH) begin
            len = LC_W'(MAX_LENGTH);
        end else begin
            len = LC_W'(i_cfg.sequence_length);
        end

        if (i_cfg.out_channels == '0) begin
            n_out = OC_CNT_W'(1);
        end else if (32'(i_cfg.out_channels) > MAX_OUT_CHANNELS) begin
            n_out = OC_CNT_W'(MAX_OUT_CHANNELS);
        end else begin
            n_out = OC_CNT_W'(i_cfg.out_channels);
        end
    end

    assign idx_err  = (32'(i_oc) >= 32'(n_out)) || (32'(i_tm) >= 32'(len));
    assign pos_base = POS_W'(r_tm) - POS_W'(i_cfg.left_padding);
    assign pos_in   = !r_pos[POS_W-1] && (r_pos[POS_W-2:0] < (POS_W-1)'(len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_err   <= 1'b0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oc  <= n_oc;
        r_tm  <= n_tm;
        r_ic  <= n_ic;
        r_tp  <= n_tp;
        r_pos <= n_pos;
    end

    always_comb begin
        n_state = r_state;
        n_oc    = r_oc;
        n_tm    = r_tm;
        n_err   = r_err;
        n_ic    = r_ic;
        n_tp    = r_tp;
        n_pos   = r_pos;
        n_drain = r_drain;
        o_ctl   = '0;
        o_stat  = '0;
        o_ctl.bias_en = i_cfg.bias_enable;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_oc    = i_oc;
                    n_tm    = i_tm;
                    n_err   = idx_err;
                    n_state = idx_err ? ST_DONE : ST_BIAS;
                end
            end
            ST_BIAS: begin
                // bias read goes out now, taps start next cycle
                o_ctl.init = 1'b1;
                n_ic       = '0;
                n_tp       = '0;
                n_pos      = pos_base;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                o_ctl.tap_en = pos_in;
                if (r_tp == tap_last) begin
                    n_tp  = '0;
                    n_pos = pos_base;
                    if (r_ic == in_last) begin
                        n_drain = 1'b0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_ic = r_ic + IC_W'(1);
                    end
                end else begin
                    n_tp  = r_tp + TP_W'(1);
                    n_pos = r_pos + POS_W'(dil);
                end
            end
            ST_DRAIN: begin
                // read data then product then accumulate
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_stat.err = r_err;
                if (i_out_free) begin
                    o_stat.done = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_oc    = r_oc;
    assign o_tm    = r_tm;
    assign o_ic    = r_ic;
    assign o_tap   = r_tp;
    assign o_pos   = r_pos[LI_W-1:0];

endmodule

/* hdl/dilated_conv1d_engine.sv */
// ----------------------------------------------------------------------------
// dilated_conv1d_engine
// one-dimensional multi-channel dilated convolution with zero padding in
// signed q11.12, built around weight, bias and sample memories
// ----------------------------------------------------------------------------
// usage
//   input channel (i_s_*): one item per load or compute request, opcode in
//   tuser. load items write one memory entry in the accept cycle and give no
//   result. a compute item gives one result item on the output channel.
//   configuration (i_cfg_*): single-cycle register writes, done while idle.
// throughput
//   load item: accepted while idle, and the next item may follow directly.
//   compute item: the single multiply-accumulate unit and the one read port
//   per memory give one weight/sample pair per cycle, n_in * n_taps pairs per
//   item with n_in and n_taps the clamped register values, up to 512 per item;
//   an index error skips the pairs.
//   no new item is accepted while a compute item is in progress.
// reset
//   registers return to 1,1,1,1,0,1,1; memories keep their contents and are
//   undefined until loaded, so there is no clearing pass.
// stalls
//   the result sits in an output register; loads are still taken while it
//   waits, and a following compute item finishes and then holds until the
//   output register frees.
// ----------------------------------------------------------------------------
module dilated_conv1d_engine #(
    parameter int MAX_IN_CHANNELS  = 64,
    parameter int MAX_OUT_CHANNELS = 64,
    parameter int MAX_TAPS         = 8,
    parameter int MAX_LENGTH       = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input items
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // out_chan[5:0], in_chan[11:6], tap[14:12], time_pos[23:15],
    // load_value[47:24]
    input  logic [dc1d_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // opcode[1:0]
    input  logic [dc1d_pkg::OP_W-1:0]            i_s_tuser,
    // result items
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // conv_value[23:0], result_chan[29:24], result_time[38:30], zero[39]
    output logic [dc1d_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // saturated[0], index_error[1]
    output logic [dc1d_pkg::OUT_TUSER_W-1:0]     o_m_tuser,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [dc1d_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dc1d_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dc1d_pkg::*;

    localparam int IC_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int TP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LI_W = $clog2(MAX_LENGTH);

    // input item fields
    t_opcode                  s_op;
    logic [CHAN_W-1:0]        s_oc;
    logic [CHAN_W-1:0]        s_ic;
    logic [TAP_W-1:0]         s_tap;
    logic [TIME_W-1:0]        s_tm;
    logic signed [DATA_W-1:0] s_val;
    logic                     s_fire;

    t_cfg                     r_cfg;

    // sequencer / store / mac hookup
    logic                     seq_ready;
    logic [CHAN_W-1:0]        seq_oc;
    logic [TIME_W-1:0]        seq_tm;
    logic [IC_W-1:0]          seq_ic;
    logic [TP_W-1:0]          seq_tap;
    logic [LI_W-1:0]          seq_pos;
    t_mac_ctl                 mac_ctl;
    t_seq_stat                seq_stat;
    logic signed [DATA_W-1:0] w_data;
    logic signed [DATA_W-1:0] b_data;
    logic signed [DATA_W-1:0] smp_data;
    logic signed [DATA_W-1:0] mac_res;
    logic                     mac_sat;
    logic                     out_free;

    // output register
    logic                     r_m_tvalid;
    logic [DATA_W-1:0]        r_m_value;
    logic [CHAN_W-1:0]        r_m_chan;
    logic [TIME_W-1:0]        r_m_time;
    logic                     r_m_sat;
    logic                     r_m_err;

    assign s_op  = t_opcode'(i_s_tuser);
    assign s_oc  = i_s_tdata[5:0];
    assign s_ic  = i_s_tdata[11:6];
    assign s_tap = i_s_tdata[14:12];
    assign s_tm  = i_s_tdata[23:15];
    assign s_val = $signed(i_s_tdata[47:24]);

    assign o_s_tready = seq_ready;
    assign s_fire     = i_s_tvalid && seq_ready;
    assign out_free   = !r_m_tvalid || i_m_tready;

    // configuration registers, raw masked bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_channels     <= 7'd1;
            r_cfg.out_channels    <= 7'd1;
            r_cfg.kernel_taps     <= 4'd1;
            r_cfg.tap_spacing     <= 7'd1;
            r_cfg.left_padding    <= 9'd0;
            r_cfg.sequence_length <= 10'd1;
            r_cfg.bias_enable     <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IN_CHANNELS:     r_cfg.in_channels     <= i_cfg_data[6:0];
                CFG_OUT_CHANNELS:    r_cfg.out_channels    <= i_cfg_data[6:0];
                CFG_KERNEL_TAPS:     r_cfg.kernel_taps     <= i_cfg_data[3:0];
                CFG_TAP_SPACING:     r_cfg.tap_spacing     <= i_cfg_data[6:0];
                CFG_LEFT_PADDING:    r_cfg.left_padding    <= i_cfg_data[8:0];
                CFG_SEQUENCE_LENGTH: r_cfg.sequence_length <= i_cfg_data[9:0];
                CFG_BIAS_ENABLE:     r_cfg.bias_enable     <= i_cfg_data[0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    dc1d_seq #(
        .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
        .MAX_TAPS         (MAX_TAPS),
        .MAX_LENGTH       (MAX_LENGTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (s_fire && (s_op == OP_COMPUTE)),
        .i_oc       (s_oc),
        .i_tm       (s_tm),
        .i_out_free (out_free),
        .o_ready    (seq_ready),
        .o_oc       (seq_oc),
        .o_tm       (seq_tm),
        .o_ic       (seq_ic),
        .o_tap      (seq_tap),
        .o_pos      (seq_pos),
        .o_ctl      (mac_ctl),
        .o_stat     (seq_stat)
    );

    // loads are only taken while the sequencer is idle, so a write never
    // meets a read of the same entry
    dc1d_stores #(
        .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
        .MAX_TAPS         (MAX_TAPS),
        .MAX_LENGTH       (MAX_LENGTH)
    ) u_stores (
        .i_clk      (i_clk),
        .i_w_we     (s_fire && (s_op == OP_LOAD_WEIGHT)),
        .i_b_we     (s_fire && (s_op == OP_LOAD_BIAS)),
        .i_s_we     (s_fire && (s_op == OP_LOAD_SAMPLE)),
        .i_ld_oc    (s_oc),
        .i_ld_ic    (s_ic),
        .i_ld_tap   (s_tap),
        .i_ld_time  (s_tm),
        .i_ld_value (s_val),
        .i_rd_oc    (seq_oc),
        .i_rd_ic    (seq_ic),
        .i_rd_tap   (seq_tap),
        .i_rd_pos   (seq_pos),
        .o_w_data   (w_data),
        .o_b_data   (b_data),
        .o_s_data   (smp_data)
    );

    dc1d_mac #(
        .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
        .MAX_TAPS        (MAX_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_w     (w_data),
        .i_s     (smp_data),
        .i_b     (b_data),
        .o_res   (mac_res),
        .o_sat   (mac_sat)
    );

    // result register, loaded when the sequencer hands off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (seq_stat.done) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.done) begin
            // index error gives zero and no saturation
            r_m_value <= seq_stat.err ? '0 : mac_res;
            r_m_sat   <= seq_stat.err ? 1'b0 : mac_sat;
            r_m_err   <= seq_stat.err;
            r_m_chan  <= seq_oc;
            r_m_time  <= seq_tm;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {1'b0, r_m_time, r_m_chan, r_m_value};
    assign o_m_tuser  = {r_m_err, r_m_sat};

`ifndef SYNTHESIS
    // a compute item keeps the input closed for at least the next cycle
    a_compute_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == OP_COMPUTE)) |=> !o_s_tready)
        else $error("input open right after a compute item");

    // a load item never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser != OP_COMPUTE) && !o_m_tvalid)
        |=> !o_m_tvalid)
        else $error("result appeared after a load item");

    // index error results carry zero and no saturation
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> ((o_m_tdata[23:0] == '0) && !o_m_tuser[0]))
        else $error("index error result not zero");

    // a saturated result sits on one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |->
        ((o_m_tdata[23:0] == 24'h7fffff) || (o_m_tdata[23:0] == 24'h800000)))
        else $error("saturated result off the limits");
`endif

endmodule
